@@ design/ssct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssct_pkg
// Shared types and codes for the sparse-set component table.
// ----------------------------------------------------------------------------
package ssct_pkg;

    localparam int MAX_ENTITY_COUNT_DEF = 1024;
    localparam int COMPONENT_BITS_DEF   = 32;

    localparam int REQ_W   = 2;
    localparam int ENT_W   = 10;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ENT_W-1:0]  entity_id;
        logic [WORD_W-1:0] component_word;
    } t_in_beat;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [WORD_W-1:0]  read_word;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] live_count;
    } t_out_beat;

endpackage

@@ design/ssct_sparse_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssct_sparse_map
// Entity-indexed map of {valid, slot}. Swept to empty after reset.
// ----------------------------------------------------------------------------
module ssct_sparse_map #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    output logic          o_busy
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

@@ design/ssct_dense_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssct_dense_store
// Slot-indexed store of {entity, component word}.
// ----------------------------------------------------------------------------
module ssct_dense_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 42
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sparse_set_component_table_core.sv @@
`timescale 1ns / 1ps
// Add, miss and unknown requests finish in S_LOOK, after the sparse map read;
// remove and get finish in S_FIX, after a dependent access (sparse map read, then
// the dense store read for get, the clearing write for remove).
// One request in flight: the next is accepted only after the last result has
// loaded the output register, later while it waits in S_HOLD behind a stalled output.
// Reset: sparse map swept empty entry by entry, input stalled meanwhile.
// ----------------------------------------------------------------------------
// sparse_set_component_table_core
// Swap-remove sparse set: add, remove and get of one component per entity.
// ----------------------------------------------------------------------------
module sparse_set_component_table_core #(
    parameter int MAX_ENTITY_COUNT = ssct_pkg::MAX_ENTITY_COUNT_DEF,
    parameter int COMPONENT_BITS   = ssct_pkg::COMPONENT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ssct_pkg::t_in_beat i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssct_pkg::t_out_beat o_out_data
);

    localparam int SAW = $clog2(MAX_ENTITY_COUNT);
    localparam int CW  = $clog2(MAX_ENTITY_COUNT + 1);
    localparam int SPW = SAW + 1;
    localparam int DNW = ssct_pkg::ENT_W + COMPONENT_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    ssct_pkg::t_in_beat  r_req, n_req;
    logic [SAW-1:0]      r_slot, n_slot;
    ssct_pkg::t_out_beat r_res, n_res;
    ssct_pkg::t_out_beat r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic           sp_we, sp_busy;
    logic [SAW-1:0] sp_waddr, sp_raddr;
    logic [SPW-1:0] sp_wdata, sp_rdata;
    logic           dn_we;
    logic [SAW-1:0] dn_waddr, dn_raddr;
    logic [DNW-1:0] dn_wdata, dn_rdata;

    logic                          sp_valid;
    logic [SAW-1:0]                sp_slot;
    logic [ssct_pkg::ENT_W-1:0]    dn_ent;
    logic [COMPONENT_BITS-1:0]     dn_word;
    logic                          in_range;
    logic [SAW-1:0]                last;
    logic                          accept, can_load, finish, load;
    ssct_pkg::t_out_beat           fin_res, load_res;

    ssct_sparse_map #(
        .DEPTH (MAX_ENTITY_COUNT),
        .AW    (SAW),
        .DW    (SPW)
    ) u_sparse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (sp_we),
        .i_waddr (sp_waddr),
        .i_wdata (sp_wdata),
        .i_raddr (sp_raddr),
        .o_rdata (sp_rdata),
        .o_busy  (sp_busy)
    );

    ssct_dense_store #(
        .DEPTH (MAX_ENTITY_COUNT),
        .AW    (SAW),
        .DW    (DNW)
    ) u_dense (
        .i_clk   (i_clk),
        .i_we    (dn_we),
        .i_waddr (dn_waddr),
        .i_wdata (dn_wdata),
        .i_raddr (dn_raddr),
        .o_rdata (dn_rdata)
    );

    assign sp_valid = sp_rdata[SAW];
    assign sp_slot  = sp_rdata[SAW-1:0];
    assign dn_ent   = dn_rdata[DNW-1 -: ssct_pkg::ENT_W];
    assign dn_word  = dn_rdata[COMPONENT_BITS-1:0];
    assign in_range = 32'(r_req.entity_id) < 32'(MAX_ENTITY_COUNT);
    assign last     = SAW'(r_count - CW'(1));

    assign o_in_stall = (r_state != S_IDLE) || sp_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign can_load   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_req    = r_req;
        n_slot   = r_slot;
        n_res    = r_res;
        finish   = 1'b0;
        load     = 1'b0;
        load_res = r_res;
        fin_res  = '0;
        fin_res.status = ssct_pkg::ST_OK;
        sp_we    = 1'b0;
        sp_waddr = SAW'(r_req.entity_id);
        sp_wdata = '0;
        sp_raddr = SAW'(i_in_data.entity_id);
        dn_we    = 1'b0;
        dn_waddr = sp_slot;
        dn_wdata = dn_rdata;
        dn_raddr = last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req   = i_in_data;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                dn_raddr = sp_slot;
                case (r_req.req_type)
                    ssct_pkg::REQ_ADD: begin
                        finish = 1'b1;
                        if (!in_range || sp_valid) begin
                            fin_res.status = ssct_pkg::ST_MISS;
                        end else if (r_count == CW'(MAX_ENTITY_COUNT)) begin
                            fin_res.status = ssct_pkg::ST_FULL;
                        end else begin
                            sp_we    = 1'b1;
                            sp_wdata = {1'b1, SAW'(r_count)};
                            dn_we    = 1'b1;
                            dn_waddr = SAW'(r_count);
                            dn_wdata = {r_req.entity_id,
                                        COMPONENT_BITS'(r_req.component_word)};
                            n_count  = r_count + CW'(1);
                            fin_res.slot_index = ssct_pkg::SLOT_W'(r_count);
                        end
                    end
                    ssct_pkg::REQ_REMOVE: begin
                        if (!in_range || !sp_valid || r_count == '0) begin
                            fin_res.status = ssct_pkg::ST_MISS;
                            finish = 1'b1;
                        end else begin
                            // move last slot into the hole
                            if (sp_slot != last) begin
                                dn_we    = 1'b1;
                                dn_waddr = sp_slot;
                                dn_wdata = dn_rdata;
                                sp_we    = 1'b1;
                                sp_waddr = SAW'(dn_ent);
                                sp_wdata = {1'b1, sp_slot};
                            end
                            n_state = S_FIX;
                        end
                    end
                    ssct_pkg::REQ_GET: begin
                        if (!in_range || !sp_valid) begin
                            fin_res.status = ssct_pkg::ST_MISS;
                            finish = 1'b1;
                        end else begin
                            n_slot  = sp_slot;
                            n_state = S_FIX;
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_FIX: begin
                finish = 1'b1;
                if (r_req.req_type == ssct_pkg::REQ_REMOVE) begin
                    sp_we    = 1'b1;
                    sp_wdata = '0;
                    n_count  = r_count - CW'(1);
                end else begin
                    fin_res.read_word  = ssct_pkg::WORD_W'(dn_word);
                    fin_res.slot_index = ssct_pkg::SLOT_W'(r_slot);
                end
            end
            S_HOLD: begin
                if (can_load) begin
                    load     = 1'b1;
                    load_res = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        fin_res.live_count = ssct_pkg::COUNT_W'(n_count);

        if (finish) begin
            if (can_load) begin
                load     = 1'b1;
                load_res = fin_res;
                n_state  = S_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = S_HOLD;
            end
        end

        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (load) begin
            n_out_valid = 1'b1;
            n_out       = load_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ verif/ssct_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssct_checker
// Watches both channels of the sparse-set component table. Every accepted
// request is run through a local swap-remove model. The result it gives is
// queued, and each accepted output beat is compared field by field with the
// oldest queued result. Reports the failure count and the number of results
// still outstanding.
// ----------------------------------------------------------------------------
module ssct_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  ssct_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  ssct_pkg::t_out_beat i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import ssct_pkg::*;

    localparam int ENTITIES = MAX_ENTITY_COUNT_DEF;

    logic              present     [ENTITIES];
    logic [SLOT_W-1:0] slot_of     [ENTITIES];
    logic [ENT_W-1:0]  entity_at   [ENTITIES];
    logic [WORD_W-1:0] word_at     [ENTITIES];
    logic [COUNT_W-1:0] live_total;

    t_out_beat expected_results[$];
    t_out_beat want;
    t_out_beat got;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_out_beat apply_request(input t_in_beat req);
        t_out_beat         res;
        logic [SLOT_W-1:0] hole;
        logic [SLOT_W-1:0] last;
        logic [SLOT_W-1:0] slot;
        logic [ENT_W-1:0]  mover;
        res        = '0;
        res.status = ST_OK;
        case (req.req_type)
            REQ_ADD: begin
                if (present[req.entity_id]) begin
                    res.status = ST_MISS;
                end else if (live_total >= COUNT_W'(ENTITIES)) begin
                    res.status = ST_FULL;
                end else begin
                    slot                  = live_total[SLOT_W-1:0];
                    present[req.entity_id] = 1'b1;
                    slot_of[req.entity_id] = slot;
                    entity_at[slot]        = req.entity_id;
                    word_at[slot]          = req.component_word;
                    live_total             = live_total + 1'b1;
                    res.slot_index         = slot;
                end
            end
            REQ_REMOVE: begin
                if (!present[req.entity_id] || live_total == '0) begin
                    res.status = ST_MISS;
                end else begin
                    hole = slot_of[req.entity_id];
                    last = live_total[SLOT_W-1:0] - 1'b1;
                    // fill the hole with the last live slot
                    if (hole != last) begin
                        mover           = entity_at[last];
                        word_at[hole]   = word_at[last];
                        slot_of[mover]  = hole;
                        entity_at[hole] = mover;
                    end
                    present[req.entity_id] = 1'b0;
                    live_total             = live_total - 1'b1;
                end
            end
            REQ_GET: begin
                if (!present[req.entity_id]) begin
                    res.status = ST_MISS;
                end else begin
                    slot           = slot_of[req.entity_id];
                    res.read_word  = word_at[slot];
                    res.slot_index = slot;
                end
            end
            default: begin
            end
        endcase
        res.live_count = live_total;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTITIES; i++) begin
                present[i]   = 1'b0;
                slot_of[i]   = '0;
                entity_at[i] = '0;
                word_at[i]   = '0;
            end
            live_total = '0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_request(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected out beat, expected none, actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.read_word !== want.read_word) begin
                        $display("%0t: read_word mismatch, expected %h, actual %h",
                                 $time, want.read_word, got.read_word);
                        o_fail_count++;
                    end
                    if (got.slot_index !== want.slot_index) begin
                        $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                                 $time, want.slot_index, got.slot_index);
                        o_fail_count++;
                    end
                    if (got.live_count !== want.live_count) begin
                        $display("%0t: live_count mismatch, expected %0d, actual %0d",
                                 $time, want.live_count, got.live_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ verif/tb_sparse_set_component_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_set_component_table_core
// Drives add, remove and get requests into the component table: a directed
// run over the swap-remove corner cases, a random mix on a small entity pool,
// a fill of every entity up to a full table, then a random drain. The sender
// idles in bursts and the receiver stalls on its own pattern. Checking is
// done by ssct_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sparse_set_component_table_core;

    localparam logic [ssct_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int               IDLE_LIMIT  = 4000;
    localparam int               ENTITIES    = ssct_pkg::MAX_ENTITY_COUNT_DEF;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    ssct_pkg::t_in_beat  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ssct_pkg::t_out_beat out_data;

    int fail_count;
    int pending;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    always #5 clk = ~clk;

    sparse_set_component_table_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    ssct_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stall pattern: free, heavy, light or held
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(1, 40);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 0);
            2: out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= 1'b1;
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_beat(input logic [ssct_pkg::REQ_W-1:0] op,
                             input logic [ssct_pkg::ENT_W-1:0] ent,
                             input logic [ssct_pkg::WORD_W-1:0] word);
        int                 gap;
        ssct_pkg::t_in_beat beat;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                              : $urandom_range(0, 4);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        beat.req_type       = op;
        beat.entity_id      = ent;
        beat.component_word = word;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [ssct_pkg::REQ_W-1:0] pick_op(input int add_pct,
                                                            input int remove_pct,
                                                            input int get_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct) return ssct_pkg::REQ_ADD;
        if (r < add_pct + remove_pct) return ssct_pkg::REQ_REMOVE;
        if (r < add_pct + remove_pct + get_pct) return ssct_pkg::REQ_GET;
        return REQ_UNKNOWN;
    endfunction

    initial begin
        int                         r;
        int                         stride;
        int                         offset;
        logic [ssct_pkg::ENT_W-1:0] ent;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed
        send_beat(ssct_pkg::REQ_ADD,    10'd0,    32'h0000_0000);
        send_beat(ssct_pkg::REQ_ADD,    10'd1023, 32'hFFFF_FFFF);
        send_beat(ssct_pkg::REQ_ADD,    10'd0,    32'h1234_5678);  // already present
        send_beat(ssct_pkg::REQ_GET,    10'd0,    32'hFFFF_FFFF);
        send_beat(ssct_pkg::REQ_GET,    10'd1023, 32'h0000_0000);
        send_beat(ssct_pkg::REQ_GET,    10'd5,    32'h0000_0000);  // absent
        send_beat(ssct_pkg::REQ_REMOVE, 10'd5,    32'h0000_0000);  // absent
        send_beat(ssct_pkg::REQ_ADD,    10'd5,    32'hA5A5_A5A5);
        send_beat(ssct_pkg::REQ_REMOVE, 10'd0,    32'h0000_0000);  // last slot moves into slot 0
        send_beat(ssct_pkg::REQ_GET,    10'd5,    32'h0000_0000);
        send_beat(ssct_pkg::REQ_GET,    10'd0,    32'h0000_0000);
        send_beat(ssct_pkg::REQ_REMOVE, 10'd1023, 32'hFFFF_FFFF);  // last slot, no move
        send_beat(ssct_pkg::REQ_GET,    10'd5,    32'h0000_0000);
        send_beat(REQ_UNKNOWN,          10'd1023, 32'hFFFF_FFFF);
        send_beat(ssct_pkg::REQ_REMOVE, 10'd5,    32'h0000_0000);  // table becomes empty
        send_beat(ssct_pkg::REQ_REMOVE, 10'd5,    32'h0000_0000);  // remove on empty table
        send_beat(ssct_pkg::REQ_GET,    10'd1023, 32'h0000_0000);
        send_beat(REQ_UNKNOWN,          10'd0,    32'h0000_0000);

        // random mix on a small pool so requests hit
        repeat (300) begin
            r = $urandom_range(0, 99);
            if (r < 80) ent = ssct_pkg::ENT_W'($urandom_range(0, 15));
            else if (r < 85) ent = ssct_pkg::ENT_W'(1023 - $urandom_range(0, 3));
            else ent = ssct_pkg::ENT_W'($urandom_range(0, ENTITIES - 1));
            send_beat(pick_op(40, 25, 30), ent, $urandom);
        end

        // fill: odd stride walks every entity once
        stride = $urandom_range(0, ENTITIES - 1) | 1;
        offset = $urandom_range(0, ENTITIES - 1);
        for (int i = 0; i < ENTITIES; i++) begin
            ent = ssct_pkg::ENT_W'(i * stride + offset);
            send_beat(ssct_pkg::REQ_ADD, ent, $urandom);
        end

        // drain and probe from a full table
        repeat (100) begin
            ent = ssct_pkg::ENT_W'($urandom_range(0, ENTITIES - 1));
            send_beat(pick_op(25, 35, 35), ent, $urandom);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
